### sv/command_line_tokenizer_defines.svh
// Assertion macros shared by the tokenizer modules.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CLT_ASSERT(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("tokenizer assertion failed");
`define CLT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");
`else
`define CLT_ASSERT(label, clk, rstn, prop)
`define CLT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### sv/clt_pkg.sv
// Types and constants shared by the command line tokenizer.
package clt_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic KIND_TOKEN   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [6:0] TOTAL_CAP = 7'd127;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic        result_kind;
		logic [6:0]  token_index;
		logic [10:0] token_start;
		logic [10:0] token_length;
		logic        was_quoted;
		logic [6:0]  arg_count;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

### sv/clt_text_if.sv
// Handshake interfaces for the text byte input and the result output.
interface clt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface clt_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [6:0]  token_index;
	logic [10:0] token_start;
	logic [10:0] token_length;
	logic        was_quoted;
	logic [6:0]  arg_count;
	logic        last_of_run;

	modport source (output valid, output result_kind, output token_index,
		output token_start, output token_length, output was_quoted,
		output arg_count, output last_of_run, input ready);
	modport sink (input valid, input result_kind, input token_index,
		input token_start, input token_length, input was_quoted,
		input arg_count, input last_of_run, output ready);
endinterface

### sv/clt_parse.sv
// Parser state and the per-byte step that yields up to two results.
`include "command_line_tokenizer_defines.svh"

module clt_parse #(
	parameter int MAX_TOKENS = 80,
	parameter int MAX_TEXT   = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    text_byte,
	input  logic          end_of_text,
	output clt_pkg::push_t push
);
	import clt_pkg::*;

	localparam int PW = $clog2(MAX_TEXT);
	localparam logic [PW-1:0] POS_LIM = PW'(MAX_TEXT - 1);
	localparam logic [7:0] TOK_MAX8 = 8'(MAX_TOKENS);

	localparam logic [2:0] M_BETWEEN       = 3'd0;
	localparam logic [2:0] M_WORD          = 3'd1;
	localparam logic [2:0] M_QUOTE         = 3'd2;
	localparam logic [2:0] M_SLASH         = 3'd3;
	localparam logic [2:0] M_COMMENT       = 3'd4;
	localparam logic [2:0] M_AFTER_COMMENT = 3'd5;
	localparam logic [2:0] M_DONE          = 3'd6;

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] x);
		return (x < POS_LIM) ? x + PW'(1) : POS_LIM;
	endfunction

	function automatic logic [6:0] stored(input logic [7:0] x);
		return (x < TOK_MAX8) ? x[6:0] : TOK_MAX8[6:0];
	endfunction

	logic [2:0]    mode_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] beg_q;
	logic [PW-1:0] size_q;
	logic [6:0]    total_q;

	logic [2:0]    m;
	logic [2:0]    nm;
	logic [PW-1:0] npos;
	logic [PW-1:0] nbeg;
	logic [PW-1:0] nsize;
	logic [6:0]    tot_after;
	logic [7:0]    inc_total;
	logic          tok;
	logic          quo;
	logic          ended;
	logic          tok_rep;
	logic [PW+10:0] beg_ext;
	logic [PW+10:0] size_ext;
	res_t          tok_res;
	res_t          sum_res;

	always_comb begin
		m = mode_q;
		if (mode_q == M_SLASH && text_byte != CH_SLASH) begin
			m = M_WORD;
		end
		nm = m;
		nbeg = beg_q;
		nsize = size_q;
		tok = 1'b0;
		quo = 1'b0;
		ended = 1'b0;
		case (m)
			M_SLASH: begin
				nm = M_COMMENT;
			end
			M_WORD: begin
				if (text_byte > CH_SPACE) begin
					nsize = sat_inc(size_q);
				end else begin
					tok = 1'b1;
					nm = M_BETWEEN;
					if (text_byte == CH_NUL || text_byte == CH_NL) begin
						ended = 1'b1;
					end
				end
			end
			M_QUOTE: begin
				if (text_byte == CH_QUOTE) begin
					tok = 1'b1;
					quo = 1'b1;
					nm = M_BETWEEN;
				end else if (text_byte == CH_NUL) begin
					tok = 1'b1;
					quo = 1'b1;
					nm = M_BETWEEN;
					ended = 1'b1;
				end else begin
					nsize = sat_inc(size_q);
				end
			end
			M_COMMENT: begin
				if (text_byte == CH_NUL) begin
					ended = 1'b1;
				end else if (text_byte == CH_NL) begin
					nm = M_AFTER_COMMENT;
				end
			end
			default: begin
				if (text_byte == CH_NUL) begin
					ended = 1'b1;
				end else if (text_byte <= CH_SPACE) begin
					if (text_byte == CH_NL && m == M_BETWEEN) begin
						ended = 1'b1;
					end
				end else if (text_byte == CH_QUOTE) begin
					nm = M_QUOTE;
					nbeg = sat_inc(pos_q);
					nsize = '0;
				end else begin
					nm = (text_byte == CH_SLASH) ? M_SLASH : M_WORD;
					nbeg = pos_q;
					nsize = PW'(1);
				end
			end
		endcase

		npos = ended ? pos_q : sat_inc(pos_q);

		if (end_of_text && !ended) begin
			if (nm == M_WORD || nm == M_SLASH) begin
				tok = 1'b1;
			end else if (nm == M_QUOTE) begin
				tok = 1'b1;
				quo = 1'b1;
			end
			ended = 1'b1;
		end

		inc_total = {1'b0, total_q} + 8'd1;
		tot_after = total_q;
		if (tok && total_q < TOTAL_CAP) begin
			tot_after = inc_total[6:0];
		end
		tok_rep = tok && (total_q < TOK_MAX8[6:0]);

		beg_ext = {11'b0, nbeg};
		size_ext = {11'b0, nsize};

		tok_res.result_kind = KIND_TOKEN;
		tok_res.token_index = total_q;
		tok_res.token_start = beg_ext[10:0];
		tok_res.token_length = size_ext[10:0];
		tok_res.was_quoted = quo;
		tok_res.arg_count = stored(inc_total);
		tok_res.last_of_run = !ended;

		sum_res.result_kind = KIND_SUMMARY;
		sum_res.token_index = '0;
		sum_res.token_start = '0;
		sum_res.token_length = '0;
		sum_res.was_quoted = 1'b0;
		sum_res.arg_count = stored({1'b0, tot_after});
		sum_res.last_of_run = 1'b1;

		push.n = 2'({1'b0, tok_rep} + {1'b0, ended});
		push.r0 = tok_rep ? tok_res : sum_res;
		push.r1 = sum_res;
		if (!step || mode_q == M_DONE) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BETWEEN;
			pos_q <= '0;
			beg_q <= '0;
			size_q <= '0;
			total_q <= '0;
		end else if (step) begin
			if (mode_q == M_DONE) begin
				if (end_of_text) begin
					mode_q <= M_BETWEEN;
				end
			end else if (ended) begin
				mode_q <= end_of_text ? M_BETWEEN : M_DONE;
				pos_q <= '0;
				beg_q <= '0;
				size_q <= '0;
				total_q <= '0;
			end else begin
				mode_q <= nm;
				pos_q <= npos;
				beg_q <= nbeg;
				size_q <= nsize;
				total_q <= tot_after;
			end
		end
	end

	`CLT_ASSERT(a_pair_order, clk, arst_n, (push.n == 2'd2) |-> (push.r0.result_kind == KIND_TOKEN && push.r1.result_kind == KIND_SUMMARY))
	`CLT_ASSERT(a_single_last, clk, arst_n, (push.n == 2'd1) |-> push.r0.last_of_run)
	`CLT_ASSERT_NEXT(a_early_end, clk, arst_n, step && mode_q != M_DONE && ended && !end_of_text, mode_q == M_DONE)

endmodule

### sv/clt_outq.sv
// Result queue that takes up to two words a cycle and hands out one.
`include "command_line_tokenizer_defines.svh"

module clt_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  clt_pkg::push_t      push,
	output logic                room,
	clt_result_if.source        result
);
	import clt_pkg::*;

	res_t             mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q;
	logic [OQ_AW-1:0] rd_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             pop;
	res_t             head;

	assign pop = result.valid && result.ready;
	assign room = (cnt_q <= OQ_CW'(OQ_DEPTH - 2));
	assign head = mem[rd_q];

	assign result.valid = (cnt_q != '0);
	assign result.result_kind = head.result_kind;
	assign result.token_index = head.token_index;
	assign result.token_start = head.token_start;
	assign result.token_length = head.token_length;
	assign result.was_quoted = head.was_quoted;
	assign result.arg_count = head.arg_count;
	assign result.last_of_run = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_q + OQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + OQ_AW'(push.n);
			if (pop) begin
				rd_q <= rd_q + OQ_AW'(1);
			end
			cnt_q <= cnt_q + OQ_CW'(push.n) - OQ_CW'(pop);
		end
	end

	`CLT_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= OQ_CW'(OQ_DEPTH))
	`CLT_ASSERT(a_push_room, clk, arst_n, (push.n != 2'd0) |-> room)

endmodule

### sv/command_line_tokenizer.sv
// Top level of the quote and comment aware command line tokenizer.
//
// Bytes of a command text enter on the text channel, one word per handshake,
// with end_of_text marking the last byte of a command. Each byte gives zero,
// one or two words on the result channel: a token report (index, start
// offset, length, quoted flag) and/or an end-of-command summary carrying the
// argument count; last_of_run marks the final word caused by a byte.
// A byte is taken into an input register, processed by the parser step once
// the queue has room, and written into a four-word result queue whose head is
// offered on the result channel.
// Throughput is one byte per cycle while the queue has room; a byte that gives
// two results hands the output side two words, which the queue absorbs until
// it fills. A held byte leaves the input register only while the queue has
// room for two words, so a stalled receiver back-pressures the input and no
// word is lost.
// Reset (arst_n low) empties the queue and returns the parser to the start
// of a fresh command at offset zero.
module command_line_tokenizer #(
	parameter int MAX_TOKENS = 80,
	parameter int MAX_TEXT   = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	clt_text_if.sink     text,
	clt_result_if.source result
);
	import clt_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       room;
	logic       step;
	push_t      push;

	assign step = v_s1 && room;
	assign text.ready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			eot_s1 <= text.end_of_text;
		end
	end

	clt_parse #(
		.MAX_TOKENS (MAX_TOKENS),
		.MAX_TEXT   (MAX_TEXT)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.push        (push)
	);

	clt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

### tb/clt_checker.sv
// Scoreboard that predicts the tokenizer's result words and compares them.
`timescale 1ns / 100ps

module clt_checker #(
	parameter int MAX_TOKENS = 80,
	parameter int MAX_TEXT   = 2048
) (
	input  logic  clk,
	input  logic  arst_n,
	clt_text_if   text,
	clt_result_if result,
	output int    mismatches,
	output int    outstanding
);
	import clt_pkg::*;

	typedef enum logic [2:0] {
		PM_BETWEEN,
		PM_WORD,
		PM_QUOTE,
		PM_SLASH,
		PM_COMMENT,
		PM_AFTER_COMMENT,
		PM_DONE
	} parse_mode_e;

	parse_mode_e mode;
	logic [10:0] pos;
	logic [10:0] tok_begin;
	logic [10:0] tok_size;
	logic [6:0]  tok_total;

	res_t byte_results[$];
	res_t expected_results[$];
	res_t oldest;

	function automatic logic [10:0] bump(logic [10:0] x);
		return (int'(x) < MAX_TEXT - 1) ? x + 11'd1 : x;
	endfunction

	function automatic logic [6:0] stored_count(int total);
		return (total < MAX_TOKENS) ? 7'(total) : 7'(MAX_TOKENS);
	endfunction

	task automatic start_fresh();
		mode = PM_BETWEEN;
		pos = '0;
		tok_begin = '0;
		tok_size = '0;
		tok_total = '0;
	endtask

	task automatic report_token(input logic quoted);
		res_t r;
		if (int'(tok_total) < MAX_TOKENS) begin
			r = '0;
			r.result_kind = KIND_TOKEN;
			r.token_index = tok_total;
			r.token_start = tok_begin;
			r.token_length = tok_size;
			r.was_quoted = quoted;
			r.arg_count = stored_count(int'(tok_total) + 1);
			byte_results.push_back(r);
		end
		if (tok_total < TOTAL_CAP)
			tok_total++;
	endtask

	// Works out the result words one text byte causes and queues them.
	task automatic tokenize_byte(input logic [7:0] b, input logic eot);
		logic ended;
		res_t r;
		ended = 1'b0;
		byte_results.delete();
		if (mode == PM_DONE) begin
			if (eot)
				start_fresh();
			return;
		end
		if (mode == PM_SLASH && b != CH_SLASH)
			mode = PM_WORD;
		case (mode)
			PM_SLASH: mode = PM_COMMENT;
			PM_WORD: begin
				if (b > CH_SPACE) begin
					tok_size = bump(tok_size);
				end else begin
					report_token(1'b0);
					mode = PM_BETWEEN;
					if (b == CH_NUL || b == CH_NL)
						ended = 1'b1;
				end
			end
			PM_QUOTE: begin
				if (b == CH_QUOTE) begin
					report_token(1'b1);
					mode = PM_BETWEEN;
				end else if (b == CH_NUL) begin
					report_token(1'b1);
					mode = PM_BETWEEN;
					ended = 1'b1;
				end else begin
					tok_size = bump(tok_size);
				end
			end
			PM_COMMENT: begin
				if (b == CH_NUL)
					ended = 1'b1;
				else if (b == CH_NL)
					mode = PM_AFTER_COMMENT;
			end
			default: begin
				if (b == CH_NUL) begin
					ended = 1'b1;
				end else if (b <= CH_SPACE) begin
					if (b == CH_NL && mode == PM_BETWEEN)
						ended = 1'b1;
				end else if (b == CH_QUOTE) begin
					mode = PM_QUOTE;
					tok_begin = bump(pos);
					tok_size = '0;
				end else begin
					mode = (b == CH_SLASH) ? PM_SLASH : PM_WORD;
					tok_begin = pos;
					tok_size = 11'd1;
				end
			end
		endcase
		if (!ended)
			pos = bump(pos);
		if (eot && !ended) begin
			if (mode == PM_WORD || mode == PM_SLASH)
				report_token(1'b0);
			else if (mode == PM_QUOTE)
				report_token(1'b1);
			ended = 1'b1;
		end
		if (ended) begin
			r = '0;
			r.result_kind = KIND_SUMMARY;
			r.arg_count = stored_count(int'(tok_total));
			byte_results.push_back(r);
			start_fresh();
			if (!eot)
				mode = PM_DONE;
		end
		if (byte_results.size() > 0)
			byte_results[$].last_of_run = 1'b1;
		foreach (byte_results[i])
			expected_results.push_back(byte_results[i]);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_fresh();
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (text.valid && text.ready)
				tokenize_byte(text.text_byte, text.end_of_text);
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: kind %0d index %0d count %0d",
						result.result_kind, result.token_index, result.arg_count);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("result_kind", oldest.result_kind, result.result_kind);
					check_field("token_index", oldest.token_index, result.token_index);
					check_field("token_start", oldest.token_start, result.token_start);
					check_field("token_length", oldest.token_length, result.token_length);
					check_field("was_quoted", oldest.was_quoted, result.was_quoted);
					check_field("arg_count", oldest.arg_count, result.arg_count);
					check_field("last_of_run", oldest.last_of_run, result.last_of_run);
				end
			end
		end
		outstanding = expected_results.size();
	end

endmodule

### tb/tb.sv
// Testbench top: drives command text into the tokenizer and gives the verdict.
`timescale 1ns / 100ps

module tb;
	import clt_pkg::*;

	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] value;
		logic       eot;
	} text_word_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   send_idle = 13;
	int   recv_idle = 45;
	int   items_sent = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	text_word_t cmd_q[$];

	clt_text_if   text_ch();
	clt_result_if result_ch();

	command_line_tokenizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	clt_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("[command_line_tokenizer] ERROR");
		$finish;
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	function automatic logic [7:0] sep_char();
		logic [7:0] v;
		v = 8'($urandom_range(1, 32));
		if (v == CH_NL || $urandom_range(0, 1) == 0)
			v = CH_SPACE;
		return v;
	endfunction

	function automatic logic [7:0] word_char();
		return 8'($urandom_range(33, 255));
	endfunction

	function automatic logic [7:0] quoted_char();
		logic [7:0] v;
		v = 8'($urandom_range(1, 255));
		return (v == CH_QUOTE) ? CH_SPACE : v;
	endfunction

	function automatic logic [7:0] comment_char();
		logic [7:0] v;
		v = 8'($urandom_range(1, 255));
		return (v == CH_NL) ? CH_SPACE : v;
	endfunction

	task automatic push(input logic [7:0] b, input logic eot = 1'b0);
		cmd_q.push_back('{value: b, eot: eot});
	endtask

	task automatic send_word(input logic [7:0] b, input logic eot);
		while ($urandom_range(0, 99) < send_idle) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_text <= eot;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_command();
		foreach (cmd_q[i])
			send_word(cmd_q[i].value, cmd_q[i].eot);
		items_sent += cmd_q.size();
		cmd_q.delete();
	endtask

	// Mostly well-formed commands with random content, some raw noise.
	task automatic build_command();
		int ntok;
		int kind;
		int ending;
		cmd_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12))
				push(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			push(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
		for (int i = 0; i < ntok; i++) begin
			if (i > 0 || $urandom_range(0, 1) == 1)
				repeat ($urandom_range(1, 2)) push(sep_char());
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				repeat ($urandom_range(1, 8)) push(word_char());
			end else if (kind < 75) begin
				push(CH_QUOTE);
				repeat ($urandom_range(0, 8)) push(quoted_char());
				if (i != ntok - 1 || $urandom_range(0, 3) != 0)
					push(CH_QUOTE);
			end else if (kind < 88) begin
				push(CH_SLASH);
				push(CH_SLASH);
				repeat ($urandom_range(0, 6)) push(comment_char());
				push(CH_NL);
				if ($urandom_range(0, 2) == 0)
					push(CH_NL);
			end else begin
				push(CH_SLASH);
				repeat ($urandom_range(0, 2)) push(word_char());
			end
		end
		ending = $urandom_range(0, 99);
		if (ending < 40 && cmd_q.size() > 0) begin
			cmd_q[$].eot = 1'b1;
		end else if (ending < 70) begin
			push(sep_char(), 1'b1);
		end else begin
			push(($urandom_range(0, 1) == 1) ? CH_NL : CH_NUL);
			repeat ($urandom_range(0, 3)) push(8'($urandom_range(0, 255)));
			push(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= '0;
		text_ch.end_of_text <= 1'b0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push("a");
		push("b", 1'b1);
		push(CH_SPACE);
		push(CH_QUOTE);
		push("q");
		push(CH_NUL);
		push("x");
		push("y", 1'b1);
		push(CH_SLASH);
		push("x");
		push(CH_SPACE);
		push(CH_SLASH, 1'b1);
		push(CH_SLASH);
		push(CH_SLASH);
		push("c");
		push(CH_NL);
		push(8'hFF);
		push(8'h80);
		push(CH_NL);
		push(8'h7F, 1'b1);
		push(CH_QUOTE);
		push(CH_QUOTE, 1'b1);
		push(CH_NUL, 1'b1);
		send_command();

		while (items_sent < 250) begin
			build_command();
			send_command();
		end

		send_idle = 45;
		recv_idle = 13;
		while (items_sent < 500) begin
			build_command();
			send_command();
		end

		send_idle = 0;
		recv_idle = 0;
		repeat (135) begin
			push(8'($urandom_range(65, 90)));
			push(CH_SPACE);
		end
		cmd_q[$].eot = 1'b1;
		send_command();

		hold_req = 1'b1;
		while (!hold_done) begin
			build_command();
			send_command();
		end
		while (items_sent < 900) begin
			build_command();
			send_command();
		end
		text_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[command_line_tokenizer] OK");
		else
			$display("[command_line_tokenizer] ERROR");
		$finish;
	end

endmodule
